// ===== hw/rtl/mhb_pkg.sv =====
// ----------------------------------------------------------------------------
// mhb_pkg
// Shared sizes and transfer payload types for the max-heap builder.
// ----------------------------------------------------------------------------
package mhb_pkg;

   // store capacity, 1..64
   localparam int MAX_ITEMS = 64;
   localparam int ADDR_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   // item count holds 0..MAX_ITEMS
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   // child index 2i+2 for i up to MAX_ITEMS-1
   localparam int CH_W      = ADDR_W + 2;
   localparam int DATA_W    = 32;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     is_last;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] heap_value;
      logic                     end_of_heap;
      logic                     overflow;
   } rsp_type;

endpackage

// ===== hw/rtl/mhb_if.sv =====
// ----------------------------------------------------------------------------
// mhb_if
// Valid/ready channels for the max-heap builder input and result streams.
// ----------------------------------------------------------------------------
interface mhb_req_if;
   logic             valid;
   logic             ready;
   mhb_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface mhb_rsp_if;
   logic             valid;
   logic             ready;
   mhb_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/max_heap_builder.sv =====
// ----------------------------------------------------------------------------
// max_heap_builder
// Loads a set of signed values, rebuilds them as a max-heap, streams it out.
// ----------------------------------------------------------------------------
// Usage:
//  req_bus : one value per transfer, level order; is_last closes the set.
//            Ready is high only while loading, one transfer per cycle.
//            Values past MAX_ITEMS are dropped and flag overflow.
//  rsp_bus : after is_last, n heap entries in index order; end_of_heap on the
//            final one, overflow on all of them if anything was dropped.
// Phases (n stored items):
//  load        values stored in arrival order at index 0..n-1
//  build       per internal node: read, latch and read children, one compare per
//              level it sinks, a put if it lands in a leaf; n/2 nodes, last to root
//  emission    a first read, then 1 result per cycle while the receiver is ready
//  The store is a two-read, one-write RAM; each sift level reads both children
//  while writing the promoted child.
// Reset clears the count and the drop flag; the store needs no clearing.
// A stalled receiver holds the current result; the RAM read for the next
// entry is issued only on the transfer, so nothing is lost.
// ----------------------------------------------------------------------------
module max_heap_builder (
   input  logic              clock,
   input  logic              reset,
   mhb_req_if.sink           req_bus,
   mhb_rsp_if.source         rsp_bus
);

   localparam int AW = mhb_pkg::ADDR_W;
   localparam int CW = mhb_pkg::CNT_W;
   localparam int HW = mhb_pkg::CH_W;
   localparam int DW = mhb_pkg::DATA_W;

   // sequencer codes
   localparam logic [2:0] S_LOAD  = 3'd0;  // taking input transfers
   localparam logic [2:0] S_START = 3'd1;  // read the node to sift
   localparam logic [2:0] S_GETV  = 3'd2;  // latch node value, read children
   localparam logic [2:0] S_CMP   = 3'd3;  // compare, promote child, descend
   localparam logic [2:0] S_PUT   = 3'd4;  // drop carried value into a leaf
   localparam logic [2:0] S_EMRD  = 3'd5;  // first emission read
   localparam logic [2:0] S_EMIT  = 3'd6;  // result on rsp_bus

   logic [2:0]           state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 dropped_ff, dropped_in;
   logic [CW-1:0]        n_ff, n_in;        // heap size of this set
   logic                 ovf_ff, ovf_in;    // overflow shown on results
   logic [CW-1:0]        k_ff, k_in;        // sift start node + 1
   logic [AW-1:0]        node_ff, node_in;  // current hole of the sift
   logic signed [DW-1:0] v_ff, v_in;        // value being sifted down
   logic [AW-1:0]        e_ff, e_in;        // emission index

   // element store: two read ports, one write port
   logic signed [DW-1:0] heap_mem [mhb_pkg::MAX_ITEMS];
   logic                 wr_en, rd_a_en, rd_b_en;
   logic [AW-1:0]        wr_addr, rd_a_addr, rd_b_addr;
   logic signed [DW-1:0] wr_data;
   logic signed [DW-1:0] rd_a_ff, rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      if (rd_a_en) begin
         rd_a_ff <= heap_mem[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_ff <= heap_mem[rd_b_addr];
      end
   end

   // child indices of the current node and of the picked child
   logic [HW-1:0]        n_ext, lc, rc, pick_lc, pick_rc;
   logic                 has_r, take_r, promote;
   logic [AW-1:0]        pick;
   logic signed [DW-1:0] pick_val;
   logic                 req_xfer, rsp_xfer, stored, last_entry;
   logic [CW-1:0]        count_inc, n_m1;

   assign n_ext    = {{(HW-CW){1'b0}}, n_ff};
   assign lc       = {1'b0, node_ff, 1'b1};
   assign rc       = lc + HW'(1);
   assign has_r    = (rc < n_ext);
   // strictly larger left child wins, ties go right
   assign take_r   = has_r && !(rd_a_ff > rd_b_ff);
   assign pick     = take_r ? rc[AW-1:0] : lc[AW-1:0];
   assign pick_val = take_r ? rd_b_ff : rd_a_ff;
   assign promote  = (pick_val > v_ff);
   assign pick_lc  = {1'b0, pick, 1'b1};
   assign pick_rc  = pick_lc + HW'(1);

   assign req_xfer   = req_bus.valid && req_bus.ready;
   assign rsp_xfer   = rsp_bus.valid && rsp_bus.ready;
   assign stored     = (count_ff < CW'(mhb_pkg::MAX_ITEMS));
   assign count_inc  = count_ff + CW'(1);
   assign n_m1       = n_ff - CW'(1);
   assign last_entry = (e_ff == n_m1[AW-1:0]);

   assign req_bus.ready            = (state_ff == S_LOAD);
   assign rsp_bus.valid            = (state_ff == S_EMIT);
   assign rsp_bus.data.heap_value  = rd_a_ff;
   assign rsp_bus.data.end_of_heap = last_entry;
   assign rsp_bus.data.overflow    = ovf_ff;

   always_comb begin
      logic sift_done;
      logic [CW-1:0] n_new;
      logic [CW-1:0] k_m1;

      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      n_in       = n_ff;
      ovf_in     = ovf_ff;
      k_in       = k_ff;
      node_in    = node_ff;
      v_in       = v_ff;
      e_in       = e_ff;
      wr_en      = 1'b0;
      wr_addr    = node_ff;
      wr_data    = v_ff;
      rd_a_en    = 1'b0;
      rd_b_en    = 1'b0;
      rd_a_addr  = lc[AW-1:0];
      rd_b_addr  = rc[AW-1:0];
      sift_done  = 1'b0;
      n_new      = stored ? count_inc : count_ff;
      k_m1       = k_ff - CW'(1);

      case (state_ff)
         S_LOAD: begin
            if (req_xfer) begin
               if (stored) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[AW-1:0];
                  wr_data  = req_bus.data.value;
                  count_in = count_inc;
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_bus.data.is_last) begin
                  n_in   = n_new;
                  ovf_in = dropped_ff || !stored;
                  k_in   = n_new >> 1;
                  e_in   = '0;
                  // a single element is already a heap
                  state_in = ((n_new >> 1) == '0) ? S_EMRD : S_START;
               end
            end
         end
         S_START: begin
            node_in   = k_m1[AW-1:0];
            rd_a_en   = 1'b1;
            rd_a_addr = k_m1[AW-1:0];
            state_in  = S_GETV;
         end
         S_GETV: begin
            // internal node: left child always exists
            v_in     = rd_a_ff;
            rd_a_en  = 1'b1;
            rd_b_en  = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            wr_en = 1'b1;
            if (promote) begin
               wr_data = pick_val;
               node_in = pick;
               if (pick_lc < n_ext) begin
                  // next level reads never hit the hole being written
                  rd_a_en   = 1'b1;
                  rd_b_en   = 1'b1;
                  rd_a_addr = pick_lc[AW-1:0];
                  rd_b_addr = pick_rc[AW-1:0];
               end else begin
                  state_in = S_PUT;
               end
            end else begin
               sift_done = 1'b1;
            end
         end
         S_PUT: begin
            wr_en     = 1'b1;
            sift_done = 1'b1;
         end
         S_EMRD: begin
            rd_a_en   = 1'b1;
            rd_a_addr = e_ff;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_xfer) begin
               if (last_entry) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = S_LOAD;
               end else begin
                  e_in      = e_ff + AW'(1);
                  rd_a_en   = 1'b1;
                  rd_a_addr = e_ff + AW'(1);
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      if (sift_done) begin
         if (k_ff == CW'(1)) begin
            e_in     = '0;
            state_in = S_EMRD;
         end else begin
            k_in     = k_m1;
            state_in = S_START;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_LOAD;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      ovf_ff  <= ovf_in;
      k_ff    <= k_in;
      node_ff <= node_in;
      v_ff    <= v_in;
      e_ff    <= e_in;
   end

`ifndef SYNTHESIS
   // loading and emitting never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_bus.ready && rsp_bus.valid))
      else $error("input and result channels active together");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(mhb_pkg::MAX_ITEMS))
      else $error("item count beyond capacity");

   // the sift hole stays inside the heap
   a_node_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP || state_ff == S_PUT) |-> ({1'b0, node_ff} < n_ff))
      else $error("sift node outside heap");

   // after the final result the next set starts clean
   a_set_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_bus.data.end_of_heap)
         |=> (count_ff == '0 && !dropped_ff && state_ff == S_LOAD))
      else $error("set not restarted after final result");
`endif

endmodule
